FILE: rtl/ccnd_pkg.sv
`default_nettype none

package ccnd_pkg;

    // Geometry limits
    localparam int MAX_SRC_DIM = 1024;
    localparam int MAX_DST_DIM = 256;

    // Register field widths
    localparam int SRC_REG_W = 11;
    localparam int DST_REG_W = 9;

    // Internal widths derived from the limits
    localparam int SRC_DIM_W = $clog2(MAX_SRC_DIM + 1);
    localparam int POS_W     = $clog2(MAX_SRC_DIM);
    localparam int DST_DIM_W = $clog2(MAX_DST_DIM + 1);
    localparam int SUM_W     = POS_W + DST_DIM_W + 1;

    // Payload widths
    localparam int PIX_W     = 8;
    localparam int OUT_IDX_W = 8;

    // Configuration port
    localparam int PDATA_W = 32;
    localparam int NUM_REGS = 4;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_idx_t;

    localparam logic [SRC_REG_W-1:0] RST_SRC_WIDTH  = 11'd320;
    localparam logic [SRC_REG_W-1:0] RST_SRC_HEIGHT = 11'd240;
    localparam logic [DST_REG_W-1:0] RST_DST_WIDTH  = 9'd48;
    localparam logic [DST_REG_W-1:0] RST_DST_HEIGHT = 9'd48;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic [OUT_IDX_W-1:0] dst_col;
        logic [OUT_IDX_W-1:0] dst_row;
        logic                 frame_done;
    } out_item_t;

    // Working geometry derived from the registers
    typedef struct packed {
        logic [SRC_DIM_W-1:0] w;
        logic [SRC_DIM_W-1:0] h;
        logic [SRC_DIM_W-1:0] crop;
        logic [POS_W-1:0]     cx;
        logic [POS_W-1:0]     cy;
        logic [DST_DIM_W-1:0] dw;
        logic [DST_DIM_W-1:0] dh;
    } geom_t;

    // Result of one axis tracker for the current position
    typedef struct packed {
        logic                 match;
        logic                 last;
        logic [OUT_IDX_W-1:0] idx;
    } axis_res_t;

    function automatic logic [SRC_DIM_W-1:0] clamp_src(input logic [SRC_REG_W-1:0] v);
        logic [SRC_DIM_W-1:0] r;
        if (v == '0)
            r = SRC_DIM_W'(1);
        else if (SRC_DIM_W'(v) > SRC_DIM_W'(MAX_SRC_DIM) || v > SRC_REG_W'(MAX_SRC_DIM))
            r = SRC_DIM_W'(MAX_SRC_DIM);
        else
            r = SRC_DIM_W'(v);
        return r;
    endfunction

    function automatic logic [DST_DIM_W-1:0] clamp_dst(input logic [DST_REG_W-1:0] v,
                                                       input logic [SRC_DIM_W-1:0] crop);
        logic [DST_DIM_W-1:0] r;
        if (v == '0)
            r = DST_DIM_W'(1);
        else if (v > DST_REG_W'(MAX_DST_DIM))
            r = DST_DIM_W'(MAX_DST_DIM);
        else
            r = DST_DIM_W'(v);
        if (SRC_DIM_W'(r) > crop)
            r = DST_DIM_W'(crop);
        return r;
    endfunction

    function automatic geom_t calc_geom(input logic [SRC_REG_W-1:0] sw,
                                        input logic [SRC_REG_W-1:0] sh,
                                        input logic [DST_REG_W-1:0] dwv,
                                        input logic [DST_REG_W-1:0] dhv);
        geom_t g;
        g.w    = clamp_src(sw);
        g.h    = clamp_src(sh);
        g.crop = (g.w < g.h) ? g.w : g.h;
        g.cx   = POS_W'((g.w - g.crop) >> 1);
        g.cy   = POS_W'((g.h - g.crop) >> 1);
        g.dw   = clamp_dst(dwv, g.crop);
        g.dh   = clamp_dst(dhv, g.crop);
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ccnd_cfg.sv
`default_nettype none

module ccnd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccnd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ccnd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ccnd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic                          cfg_wr,
    output ccnd_pkg::geom_t               geom
);
    import ccnd_pkg::*;

    logic [SRC_REG_W-1:0] src_width_reg;
    logic [SRC_REG_W-1:0] src_height_reg;
    logic [DST_REG_W-1:0] dst_width_reg;
    logic [DST_REG_W-1:0] dst_height_reg;
    geom_t                geom_reg;
    reg_idx_t             idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign geom   = geom_reg;

    // Write registers on the access phase of a write request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            dst_width_reg  <= RST_DST_WIDTH;
            dst_height_reg <= RST_DST_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[SRC_REG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[SRC_REG_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[DST_REG_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[DST_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register the clamped geometry from the raw fields, in the cycle after they change
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            geom_reg <= calc_geom(RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_DST_WIDTH, RST_DST_HEIGHT);
        else
            geom_reg <= calc_geom(src_width_reg, src_height_reg, dst_width_reg, dst_height_reg);
    end

    // Read back the raw fields
    always_comb
    begin
        unique case (idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = PDATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = PDATA_W'(dst_height_reg);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ccnd_axis.sv
`default_nettype none

// Tracks the nearest sample of one axis with running sums:
// bound = p * dn, sample = d * crop, d = smallest index with sample >= bound.
module ccnd_axis (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clear,
    input  logic                            step,
    input  logic                            use_zero,
    input  logic [ccnd_pkg::DST_DIM_W-1:0]  dn,
    input  logic [ccnd_pkg::SRC_DIM_W-1:0]  crop,
    output ccnd_pkg::axis_res_t             res
);
    import ccnd_pkg::*;

    logic [SUM_W-1:0]     bound_reg, bound_next;
    logic [SUM_W-1:0]     sample_reg, sample_next;
    logic [DST_DIM_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0]     bound_eff;
    logic [SUM_W-1:0]     sample_eff;
    logic [DST_DIM_W-1:0] idx_eff;
    logic [SUM_W-1:0]     bound_hi;

    // Position zero always starts from empty sums
    assign bound_eff  = use_zero ? '0 : bound_reg;
    assign sample_eff = use_zero ? '0 : sample_reg;
    assign idx_eff    = use_zero ? '0 : idx_reg;
    assign bound_hi   = bound_eff + SUM_W'(dn);

    // Sample lies in [bound, bound + dn) for a valid destination index
    assign res.match = (idx_eff < dn) && (sample_eff < bound_hi);
    assign res.last  = (idx_eff == dn - DST_DIM_W'(1));
    assign res.idx   = idx_eff[OUT_IDX_W-1:0];

    // Advance one position: bound grows by dn <= crop, so the index moves at most once
    always_comb
    begin
        bound_next  = bound_hi;
        sample_next = sample_eff;
        idx_next    = idx_eff;
        if (sample_eff < bound_hi)
        begin
            sample_next = sample_eff + SUM_W'(crop);
            idx_next    = idx_eff + DST_DIM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg  <= '0;
            sample_reg <= '0;
            idx_reg    <= '0;
        end
        else if (clear)
        begin
            bound_reg  <= '0;
            sample_reg <= '0;
            idx_reg    <= '0;
        end
        else if (step)
        begin
            bound_reg  <= bound_next;
            sample_reg <= sample_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/center_crop_nearest_downscaler.sv
// Pipeline: an accepted pixel request is held in the input register; a hit is
// then loaded into the output register. Throughput: one pixel per cycle while
// the output drains and no rebuild runs; the output register lets a new pixel
// in while a finished result waits. After each register write the two axis trackers
// are rebuilt from zero to the current position, one step per cycle, with src_ready low.
// Reset: asynchronous, active low; registers return to 320x240 -> 48x48 and counters to zero.
`default_nettype none

module center_crop_nearest_downscaler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_ready,
    input  ccnd_pkg::in_item_t            src_data,
    output logic                          dst_valid,
    input  logic                          dst_ready,
    output ccnd_pkg::out_item_t           dst_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccnd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ccnd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ccnd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ccnd_pkg::*;

    typedef enum logic [2:0] {
        SYNC_IDLE = 3'b001,
        SYNC_LOAD = 3'b010,
        SYNC_WALK = 3'b100
    } sync_state_t;

    sync_state_t      sync_reg, sync_next;
    logic [POS_W-1:0] walk_reg;

    logic             cfg_wr;
    geom_t            geom;

    logic             in_valid_reg;
    in_item_t         in_data_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic [POS_W-1:0] col_reg, row_reg;
    logic [POS_W-1:0] col_cur, row_cur;
    logic [POS_W-1:0] col_pos, row_pos;
    logic             col_in, row_in;
    logic             line_end, frame_end;

    axis_res_t        col_res, row_res;
    logic             col_step, row_step;
    logic             col_walk, row_walk;
    logic             col_zero, row_zero;
    logic             walking;

    logic             hit;
    logic             proc;

    ccnd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_wr  (cfg_wr),
        .geom    (geom)
    );

    // Current source position; a frame start restarts it at the origin
    assign col_cur = (in_valid_reg && in_data_reg.frame_start) ? '0 : col_reg;
    assign row_cur = (in_valid_reg && in_data_reg.frame_start) ? '0 : row_reg;

    // Crop-relative position and crop window test
    assign col_pos = col_cur - geom.cx;
    assign row_pos = row_cur - geom.cy;
    assign col_in  = (col_cur >= geom.cx) && (SRC_DIM_W'(col_pos) < geom.crop);
    assign row_in  = (row_cur >= geom.cy) && (SRC_DIM_W'(row_pos) < geom.crop);

    assign line_end  = (SRC_DIM_W'(col_cur) + SRC_DIM_W'(1)) >= geom.w;
    assign frame_end = (SRC_DIM_W'(row_cur) + SRC_DIM_W'(1)) >= geom.h;

    // Rebuild steps: position p needs p advances from zero
    assign walking  = (sync_reg == SYNC_WALK);
    assign col_walk = col_in && (walk_reg < col_pos);
    assign row_walk = row_in && (walk_reg < row_pos);

    assign col_zero = !walking && (col_pos == '0);
    assign row_zero = !walking && (row_pos == '0);
    assign col_step = walking ? col_walk : proc;
    assign row_step = walking ? row_walk : (proc && line_end);

    ccnd_axis u_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (sync_reg == SYNC_LOAD),
        .step     (col_step),
        .use_zero (col_zero),
        .dn       (geom.dw),
        .crop     (geom.crop),
        .res      (col_res)
    );

    ccnd_axis u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (sync_reg == SYNC_LOAD),
        .step     (row_step),
        .use_zero (row_zero),
        .dn       (geom.dh),
        .crop     (geom.crop),
        .res      (row_res)
    );

    // Pixel selection and pipeline flow
    assign hit       = col_in && row_in && col_res.match && row_res.match;
    assign proc      = in_valid_reg && (!out_valid_reg || dst_ready || !hit);
    assign src_ready = (sync_reg == SYNC_IDLE) && (!in_valid_reg || proc);
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;

    // Hold the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (src_valid && src_ready)
            in_valid_reg <= 1'b1;
        else if (proc)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            in_data_reg <= src_data;
    end

    // Advance the raster counters, wrapping at line and frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (proc)
        begin
            if (line_end)
            begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_cur + POS_W'(1);
            end
            else
            begin
                col_reg <= col_cur + POS_W'(1);
                row_reg <= row_cur;
            end
        end
    end

    // Output register: load on a hit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && hit)
            out_valid_reg <= 1'b1;
        else if (dst_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && hit)
        begin
            out_data_reg.pixel_out  <= in_data_reg.pixel_in;
            out_data_reg.dst_col    <= col_res.idx;
            out_data_reg.dst_row    <= row_res.idx;
            out_data_reg.frame_done <= col_res.last && row_res.last;
        end
    end

    // Tracker rebuild sequencer after register writes
    always_comb
    begin
        sync_next = sync_reg;
        unique case (sync_reg)
            SYNC_IDLE: sync_next = SYNC_IDLE;
            SYNC_LOAD: sync_next = SYNC_WALK;
            SYNC_WALK: sync_next = (col_walk || row_walk) ? SYNC_WALK : SYNC_IDLE;
            default:   sync_next = SYNC_IDLE;
        endcase
        if (cfg_wr)
            sync_next = SYNC_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_IDLE;
            walk_reg <= '0;
        end
        else
        begin
            sync_reg <= sync_next;
            if (sync_reg == SYNC_LOAD)
                walk_reg <= '0;
            else if (walking)
                walk_reg <= walk_reg + POS_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
module tb_top;
    import ccnd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int STALL_CYCLES  = 80;
    localparam int LARGE_ITEMS   = 260;

    localparam logic [PIX_W-1:0] PATTERN_PIX [15] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE,
        8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h00, 8'hFF, 8'h11
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_ready;
    in_item_t           src_data  = '0;
    logic               dst_valid;
    logic               dst_ready = 1'b0;
    out_item_t          dst_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow registers and scan position of the predictor
    logic [SRC_REG_W-1:0] cfg_src_w = RST_SRC_WIDTH;
    logic [SRC_REG_W-1:0] cfg_src_h = RST_SRC_HEIGHT;
    logic [DST_REG_W-1:0] cfg_dst_w = RST_DST_WIDTH;
    logic [DST_REG_W-1:0] cfg_dst_h = RST_DST_HEIGHT;
    logic [POS_W-1:0]     scan_col  = '0;
    logic [POS_W-1:0]     scan_row  = '0;

    out_item_t   expected_pixels[$];
    out_item_t   oldest_pixel;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    bit          src_gaps_on     = 1'b1;
    bit          rx_gaps_on      = 1'b1;
    int unsigned rx_hold_request = 0;
    int unsigned rx_hold_left    = 0;

    center_crop_nearest_downscaler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Treat zero as one, saturate at the limit
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Smallest index whose sample lies at or after p, and whether it lands on p
    function automatic bit sample_hit(input int unsigned p, input int unsigned crop,
                                      input int unsigned dn, output int unsigned idx);
        int unsigned prod;
        prod = p * dn;
        idx  = (prod + crop - 1) / crop;
        return (idx < dn) && (idx * crop < prod + dn);
    endfunction

    // Advance the scan position by one pixel and queue the pixel if it is sampled
    function automatic void downscale_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned w, h, crop, cx, cy, dw, dh, col, row, dx, dy;
        bit          col_hit, row_hit;
        out_item_t   res;
        w    = clamp_dim(32'(cfg_src_w), MAX_SRC_DIM);
        h    = clamp_dim(32'(cfg_src_h), MAX_SRC_DIM);
        crop = (w < h) ? w : h;
        cx   = (w - crop) / 2;
        cy   = (h - crop) / 2;
        dw   = clamp_dim(32'(cfg_dst_w), MAX_DST_DIM);
        dh   = clamp_dim(32'(cfg_dst_h), MAX_DST_DIM);
        dx   = 0;
        dy   = 0;
        if (dw > crop)
            dw = crop;
        if (dh > crop)
            dh = crop;
        if (fs)
        begin
            scan_col = '0;
            scan_row = '0;
        end
        col = 32'(scan_col);
        row = 32'(scan_row);
        if (col >= cx && col - cx < crop && row >= cy && row - cy < crop)
        begin
            col_hit = sample_hit(col - cx, crop, dw, dx);
            row_hit = sample_hit(row - cy, crop, dh, dy);
            if (col_hit && row_hit)
            begin
                res.pixel_out  = pix;
                res.dst_col    = dx[OUT_IDX_W-1:0];
                res.dst_row    = dy[OUT_IDX_W-1:0];
                res.frame_done = (dx == dw - 1) && (dy == dh - 1);
                expected_pixels.push_back(res);
            end
        end
        if (col + 1 >= w)
        begin
            scan_col = '0;
            scan_row = (row + 1 >= h) ? '0 : POS_W'(row + 1);
        end
        else
            scan_col = POS_W'(col + 1);
    endfunction

    // Drop a random stall on the result side, or hold it off for a long stretch
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            dst_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end
        else if (rx_hold_request != 0)
        begin
            dst_ready <= 1'b0;
            rx_hold_left = rx_hold_request - 1;
            rx_hold_request = 0;
        end
        else
            dst_ready <= !(rx_gaps_on && $urandom_range(99) < 6);
    end

    // Compare each accepted result with the oldest expected pixel
    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_out %0d dst_col %0d dst_row %0d",
                       dst_data.pixel_out, dst_data.dst_col, dst_data.dst_row);
                error_count++;
            end
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                if (dst_data.pixel_out !== oldest_pixel.pixel_out)
                begin
                    $error("pixel_out: expected %0d, got %0d",
                           oldest_pixel.pixel_out, dst_data.pixel_out);
                    error_count++;
                end
                if (dst_data.dst_col !== oldest_pixel.dst_col)
                begin
                    $error("dst_col: expected %0d, got %0d",
                           oldest_pixel.dst_col, dst_data.dst_col);
                    error_count++;
                end
                if (dst_data.dst_row !== oldest_pixel.dst_row)
                begin
                    $error("dst_row: expected %0d, got %0d",
                           oldest_pixel.dst_row, dst_data.dst_row);
                    error_count++;
                end
                if (dst_data.frame_done !== oldest_pixel.frame_done)
                begin
                    $error("frame_done: expected %0d, got %0d",
                           oldest_pixel.frame_done, dst_data.frame_done);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Issue one pixel request and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        in_item_t item;
        item.pixel_in    = pix;
        item.frame_start = fs;
        if (src_gaps_on && $urandom_range(99) < 6)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= item;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        downscale_pixel(pix, fs);
    endtask

    // Pause requests until every expected pixel has come out, then settle
    task automatic wait_results_done();
        src_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("%s readback: expected %0d, got %0d", idx.name(), want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write one register, mirror it in the predictor, read it back
    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        logic [PDATA_W-1:0] kept;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:
            begin
                cfg_src_w = value[SRC_REG_W-1:0];
                kept      = 32'(cfg_src_w);
            end
            REG_SRC_HEIGHT:
            begin
                cfg_src_h = value[SRC_REG_W-1:0];
                kept      = 32'(cfg_src_h);
            end
            REG_DST_WIDTH:
            begin
                cfg_dst_w = value[DST_REG_W-1:0];
                kept      = 32'(cfg_dst_w);
            end
            default:
            begin
                cfg_dst_h = value[DST_REG_W-1:0];
                kept      = 32'(cfg_dst_h);
            end
        endcase
        @(posedge clk);
        check_reg(idx, kept);
    endtask

    task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                                input int unsigned dwv, input int unsigned dhv);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dwv);
        write_reg(REG_DST_HEIGHT, dhv);
    endtask

    // Small random frames, now and then a zero or oversized register
    task automatic pick_random_geometry();
        int unsigned sw, sh, dwv, dhv;
        sw  = $urandom_range(1, 12);
        sh  = $urandom_range(1, 12);
        dwv = $urandom_range(1, 12);
        dhv = $urandom_range(1, 12);
        case ($urandom_range(9))
            0: sw = 0;
            1: sh = 0;
            2: dwv = 0;
            3: dhv = $urandom_range(256, 511);
            4: dwv = $urandom_range(256, 511);
            5: dhv = 0;
            default: ;
        endcase
        set_geometry(sw, sh, dwv, dhv);
    endtask

    task automatic test_register_reset();
        check_reg(REG_SRC_WIDTH, 32'(RST_SRC_WIDTH));
        check_reg(REG_SRC_HEIGHT, 32'(RST_SRC_HEIGHT));
        check_reg(REG_DST_WIDTH, 32'(RST_DST_WIDTH));
        check_reg(REG_DST_HEIGHT, 32'(RST_DST_HEIGHT));
    endtask

    // 5x3 source: outer columns fall outside the crop, bottom row is skipped
    task automatic test_directed_frame();
        int k;
        set_geometry(5, 3, 3, 2);
        for (k = 0; k < 15; k++)
            send_pixel(PATTERN_PIX[k], k == 0);
        // run on without a start marker, then restart mid-frame
        for (k = 0; k < 6; k++)
            send_pixel(PATTERN_PIX[k + 3], 1'b0);
        for (k = 0; k < 4; k++)
            send_pixel(PATTERN_PIX[k + 8], k == 0);
        wait_results_done();
    endtask

    // All registers zero: a 1x1 frame, every pixel is the last one
    task automatic test_zero_registers();
        set_geometry(0, 0, 0, 0);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hA5, 1'b1);
        send_pixel(8'h5A, 1'b0);
        wait_results_done();
    endtask

    // Leave the scan mid-frame, then shrink the geometry under it
    task automatic test_shrunk_geometry();
        int k;
        set_geometry(10, 10, 5, 5);
        for (k = 0; k < 37; k++)
            send_pixel(PIX_W'($urandom_range(255)), k == 0);
        wait_results_done();
        set_geometry(3, 3, 3, 3);
        for (k = 0; k < 12; k++)
            send_pixel(PIX_W'($urandom_range(255)), 1'b0);
        wait_results_done();
    endtask

    // Hold off the result side while requests keep coming, so the input stalls
    task automatic test_output_stall();
        int k;
        set_geometry(8, 8, 8, 8);
        src_gaps_on     = 1'b0;
        rx_hold_request = STALL_CYCLES;
        for (k = 0; k < 64; k++)
            send_pixel(PIX_W'($urandom_range(255)), k == 0);
        wait_results_done();
        src_gaps_on = 1'b1;
    endtask

    // Oversized registers saturate to a 1024 crop and a 256 grid; cover the start of row 0
    task automatic test_large_frame();
        int k;
        set_geometry(2047, 1100, 511, 300);
        for (k = 0; k < LARGE_ITEMS; k++)
            send_pixel(PIX_W'($urandom_range(255)), k == 0);
        wait_results_done();
    endtask

    task automatic test_random_frames();
        int unsigned sent, frame_len, count, kind, k;
        sent = 0;
        // start with a stretch with no idling on either side
        src_gaps_on = 1'b0;
        rx_gaps_on  = 1'b0;
        pick_random_geometry();
        while (sent < RANDOM_ITEMS)
        begin
            if (sent > 250)
            begin
                src_gaps_on = 1'b1;
                rx_gaps_on  = 1'b1;
            end
            if ($urandom_range(3) == 0)
            begin
                wait_results_done();
                pick_random_geometry();
            end
            frame_len = clamp_dim(32'(cfg_src_w), MAX_SRC_DIM) *
                        clamp_dim(32'(cfg_src_h), MAX_SRC_DIM);
            kind  = $urandom_range(99);
            count = (kind < 80) ? frame_len : $urandom_range(1, frame_len);
            for (k = 0; k < count; k++)
            begin
                if (kind < 70 || (kind >= 80 && kind < 90))
                    send_pixel(PIX_W'($urandom_range(255)), k == 0);
                else if (kind < 80)
                    // no start marker: rely on the counters wrapping
                    send_pixel(PIX_W'($urandom_range(255)), 1'b0);
                else
                    send_pixel(PIX_W'($urandom_range(255)), $urandom_range(3) == 0);
            end
            sent += count;
        end
        wait_results_done();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_register_reset();
        test_directed_frame();
        test_zero_registers();
        test_shrunk_geometry();
        test_output_stall();
        test_large_frame();
        test_random_frames();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ccnd_pkg.sv
rtl/ccnd_cfg.sv
rtl/ccnd_axis.sv
rtl/center_crop_nearest_downscaler.sv
verif/tb_top.sv
